FILE: sv/color_string_parser_top_defines.svh
// Assertion macros shared by the color string parser.
`ifndef COLOR_STRING_PARSER_TOP_DEFINES_SVH
`define COLOR_STRING_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define CSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cspar_pkg.sv
package cspar_pkg;

  localparam int NAME_COUNT = 12;
  localparam int HEX_LEN    = 7;
  localparam int COUNT_MAX  = 15;

  localparam logic [7:0] HASH_CHAR = 8'h23;

  typedef enum logic [1:0] {
    ST_HEX  = 2'd0,
    ST_NAME = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef logic [0:NAME_COUNT-1][0:7][7:0] name_text_t;
  typedef logic [0:NAME_COUNT-1][3:0]      name_len_t;
  typedef logic [0:NAME_COUNT-1][23:0]     name_rgb_t;

  // Name characters, lower case, zero padded to eight positions.
  localparam name_text_t NAME_TEXT = '{
    '{"b", "l", "a", "c", "k", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "t", "e", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "e", "n", 8'h00, 8'h00, 8'h00},
    '{"b", "l", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"y", "e", "l", "l", "o", "w", 8'h00, 8'h00},
    '{"m", "a", "g", "e", "n", "t", "a", 8'h00},
    '{"p", "u", "r", "p", "l", "e", 8'h00, 8'h00},
    '{"o", "r", "a", "n", "g", "e", 8'h00, 8'h00},
    '{"g", "r", "a", "y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "y", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam name_len_t NAME_LEN = '{
    4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd6, 4'd7, 4'd6, 4'd6, 4'd4, 4'd4, 4'd4
  };

  localparam name_rgb_t NAME_RGB = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h008000, 24'h0000FF, 24'hFFFF00,
    24'hFF00FF, 24'h800080, 24'hFFA500, 24'h808080, 24'h808080, 24'h00FFFF
  };

  typedef struct packed {
    logic [3:0]            count;
    logic [23:0]           hex_accum;
    logic                  hex_ok;
    logic [NAME_COUNT-1:0] mask;
  } scan_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    status_t    status;
  } result_t;

  // ASCII A-Z to lower case; everything else passes.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // Bit 4 set when the byte is not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= "0" && c <= "9") begin
      d = {1'b0, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      d = {1'b0, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      d = {1'b0, 4'(c - "A" + 8'd10)};
    end
    return d;
  endfunction

endpackage

FILE: sv/cspar_scan.sv
module cspar_scan (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     ch,
  input  logic           last_char,
  output cspar_pkg::scan_t cur,
  output cspar_pkg::scan_t upd
);

  cspar_pkg::scan_t scan_r;
  cspar_pkg::scan_t scan_nxt;
  logic [7:0] lc;
  logic [4:0] dig;

  always_comb begin
    lc  = cspar_pkg::fold_case(ch);
    dig = cspar_pkg::hex_digit(ch);
    upd = scan_r;

    // hex path
    if (scan_r.count == 4'd0) begin
      if (ch != cspar_pkg::HASH_CHAR) begin
        upd.hex_ok = 1'b0;
      end
    end else if (scan_r.count < 4'(cspar_pkg::HEX_LEN)) begin
      if (dig[4]) begin
        upd.hex_ok = 1'b0;
      end else begin
        upd.hex_accum = {scan_r.hex_accum[19:0], dig[3:0]};
      end
    end else begin
      upd.hex_ok = 1'b0;
    end

    // name path: drop any name that misses at this position
    for (int i = 0; i < cspar_pkg::NAME_COUNT; i++) begin
      if (!(scan_r.count < cspar_pkg::NAME_LEN[i] &&
            lc == cspar_pkg::NAME_TEXT[i][scan_r.count[2:0]])) begin
        upd.mask[i] = 1'b0;
      end
    end

    if (scan_r.count != 4'(cspar_pkg::COUNT_MAX)) begin
      upd.count = scan_r.count + 4'd1;
    end

    scan_nxt = scan_r;
    if (step) begin
      if (last_char) begin
        scan_nxt = '{count: 4'd0, hex_accum: 24'd0, hex_ok: 1'b1, mask: '1};
      end else begin
        scan_nxt = upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '{count: 4'd0, hex_accum: 24'd0, hex_ok: 1'b1, mask: '1};
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign cur = scan_r;

endmodule

FILE: sv/cspar_resolve.sv
module cspar_resolve (
  input  cspar_pkg::scan_t   upd,
  output cspar_pkg::result_t res
);

  always_comb begin
    res = '{red: 8'd0, green: 8'd0, blue: 8'd0, status: cspar_pkg::ST_NONE};
    if (upd.hex_ok && upd.count == 4'(cspar_pkg::HEX_LEN)) begin
      res = '{red: upd.hex_accum[23:16], green: upd.hex_accum[15:8],
              blue: upd.hex_accum[7:0], status: cspar_pkg::ST_HEX};
    end else begin
      // walk down so the lowest matching name wins
      for (int i = cspar_pkg::NAME_COUNT - 1; i >= 0; i--) begin
        if (upd.mask[i] && upd.count == cspar_pkg::NAME_LEN[i]) begin
          res = '{red:    cspar_pkg::NAME_RGB[i][23:16],
                  green:  cspar_pkg::NAME_RGB[i][15:8],
                  blue:   cspar_pkg::NAME_RGB[i][7:0],
                  status: cspar_pkg::ST_NAME};
        end
      end
    end
  end

endmodule

FILE: sv/color_string_parser_top.sv
// A closing character's result beat is loaded into the result register when the
// character advances from the input register, where it waits while the result register is full.
// One character beat per cycle, set by the scan update, except while a closing character is held.
// A full result register stalls only a held closing character; other held characters keep flowing.
// Reset (rst_n low, synchronous): input and result registers empty, scan state at
// zero count, hex match armed and every name candidate live.
`include "color_string_parser_top_defines.svh"

module color_string_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [1:0] out_status
);

  // Input register: one character beat waiting for the scan logic.
  logic       in_valid_r;
  logic       in_valid_nxt;
  logic [7:0] ch_r;
  logic       last_r;

  // Result register.
  logic               out_valid_r;
  logic               out_valid_nxt;
  cspar_pkg::result_t res_r;

  cspar_pkg::scan_t   scan_cur;
  cspar_pkg::scan_t   scan_upd;
  cspar_pkg::result_t res_comb;

  logic out_free;
  logic adv;
  logic in_take;

  // The result register can load when it is empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Advance the held character into the scan state; a closing character
  // needs room in the result register, any other character never waits.
  assign adv      = in_valid_r && (!last_r || out_free);
  // Hold the input side only while the held beat cannot advance.
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  cspar_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .ch        (ch_r),
    .last_char (last_r),
    .cur       (scan_cur),
    .upd       (scan_upd)
  );

  cspar_resolve u_resolve (
    .upd (scan_upd),
    .res (res_comb)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (adv && last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: input on the taking edge, result on a closing advance; hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r   <= in_ch;
      last_r <= in_last_char;
    end
    if (adv && last_r) begin
      res_r <= res_comb;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_red    = res_r.red;
  assign out_green  = res_r.green;
  assign out_blue   = res_r.blue;
  assign out_status = res_r.status;

  // A closing character must leave the scan state back at its start.
  `CSP_ASSERT_NEXT(a_scan_restart, adv && last_r, scan_cur.count == 4'd0 && scan_cur.hex_ok, "scan state not restarted after closing character")
  // A closing character that advances must show up as a result beat.
  `CSP_ASSERT_NEXT(a_result_loaded, adv && last_r, out_valid_r, "closing character produced no result")
  // An unrecognized string reports black.
  `CSP_ASSERT_NOW(a_none_black, out_valid_r && res_r.status == cspar_pkg::ST_NONE, res_r.red == 8'd0 && res_r.green == 8'd0 && res_r.blue == 8'd0, "unrecognized result is not black")
  // Stall the input only for a held closing character facing a full result register.
  `CSP_ASSERT_NOW(a_stall_cause, in_stall, in_valid_r && last_r && out_valid_r && out_stall, "input stalled without a blocked closing character")

endmodule

FILE: tb/color_string_parser_top_test.sv
module color_string_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] HASH_BYTE  = 8'h23;
  localparam int         HEX_STRLEN = 7;
  localparam int         LEN_CAP    = 15;
  localparam int         RAND_CHARS = 1800;
  // Windows in the cycle count: no random idling inside CALM_*, long receiver
  // hold-offs starting at HOLD_AT_*.
  localparam int         CALM_LO    = 1600;
  localparam int         CALM_HI    = 2100;
  localparam int         HOLD_AT_A  = 400;
  localparam int         HOLD_AT_B  = 1200;
  localparam int         HOLD_LEN   = 120;

  typedef struct {
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    cspar_pkg::status_t  status;
  } color_t;

  // One directed string: text right-aligned, length given apart so that
  // NUL bytes can be part of it.
  typedef struct {
    logic [255:0] text;
    int           len;
    bit           fixed;
    color_t       want;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_ch;
  logic       in_last_char;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [1:0] out_status;

  color_string_parser_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ch        (in_ch),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_status   (out_status)
  );

  // Palette in priority order: the first live name of the right length wins.
  string      pal_name [12] = '{"black", "white", "red", "green", "blue", "yellow",
                                "magenta", "purple", "orange", "gray", "grey", "cyan"};
  logic [23:0] pal_rgb [12] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h008000,
                                24'h0000FF, 24'hFFFF00, 24'hFF00FF, 24'h800080,
                                24'hFFA500, 24'h808080, 24'h808080, 24'h00FFFF};

  // Scan state of the string being parsed, mirrored beat by beat.
  logic [3:0]  scan_len;
  logic [23:0] hex_digits;
  logic        hex_form;
  logic [11:0] name_live;

  color_t pending_colors [$];
  row_t   rows [$];

  int cyc = 0;
  int errors;
  int strings_sent;
  int chars_sent;
  int seen_hex;
  int seen_name;
  int seen_none;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic bit calm_window();
    return cyc >= CALM_LO && cyc < CALM_HI;
  endfunction

  function automatic void clear_scan();
    scan_len   = '0;
    hex_digits = '0;
    hex_form   = 1'b1;
    name_live  = '1;
  endfunction

  // Advance the scan by one character; return 1 with the color when the
  // character closes the string.
  function automatic bit advance_scan(input logic [7:0] c, input bit last,
                                      output color_t col);
    logic [7:0] lc;
    logic [4:0] d;
    int         pos;
    bit         found;
    pos = scan_len;
    lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    d   = 5'h10;
    if (c >= "0" && c <= "9") begin
      d = 5'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      d = 5'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      d = 5'(c - "A" + 8'd10);
    end
    // Hex form: '#' first, then six digits, nothing after.
    if (pos == 0) begin
      if (c != HASH_BYTE) hex_form = 1'b0;
    end else if (pos < HEX_STRLEN) begin
      if (d[4]) hex_form = 1'b0;
      else hex_digits = {hex_digits[19:0], d[3:0]};
    end else begin
      hex_form = 1'b0;
    end
    // Drop every name whose character at this position differs.
    for (int i = 0; i < 12; i++) begin
      if (!(pos < pal_name[i].len() && lc == pal_name[i][pos])) name_live[i] = 1'b0;
    end
    if (scan_len != LEN_CAP) scan_len = scan_len + 4'd1;
    col = '{8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE};
    if (!last) return 1'b0;
    found = 1'b0;
    if (hex_form && scan_len == HEX_STRLEN) begin
      col = '{hex_digits[23:16], hex_digits[15:8], hex_digits[7:0], cspar_pkg::ST_HEX};
    end else begin
      for (int i = 0; i < 12; i++) begin
        if (!found && name_live[i] && scan_len == pal_name[i].len()) begin
          col   = '{pal_rgb[i][23:16], pal_rgb[i][15:8], pal_rgb[i][7:0],
                    cspar_pkg::ST_NAME};
          found = 1'b1;
        end
      end
    end
    clear_scan();
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [255:0] text, input int len, input bit fixed,
                                  input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input cspar_pkg::status_t st);
    row_t row;
    row.text  = text;
    row.len   = len;
    row.fixed = fixed;
    row.want  = '{r, g, b, st};
    rows.push_back(row);
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  // Offer one character beat, called at a falling edge; return at the falling
  // edge after it was taken. Idle at random outside the calm window.
  task automatic send_char(input logic [7:0] c, input bit last, input bit fixed,
                           input color_t given);
    color_t col;
    while (!calm_window() && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      in_ch    <= 8'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_ch        <= c;
    in_last_char <= last;
    // Hold the payload until the block takes the beat.
    do @(posedge clk); while (in_stall);
    chars_sent++;
    if (advance_scan(c, last, col)) begin
      pending_colors.push_back(fixed ? given : col);
      strings_sent++;
    end
    @(negedge clk);
  endtask

  // Receiver: random stalls, two long hold-offs that fill the block up.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN - 1) @(negedge clk);
      end else begin
        out_stall <= !calm_window() && $urandom_range(0, 99) < 7;
      end
    end
  end

  // Compare every result beat with the oldest pending color.
  always @(posedge clk) begin
    color_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: result beat with nothing pending, got %0h %0h %0h status %0d",
                 $time, out_red, out_green, out_blue, out_status);
        errors++;
      end else begin
        want = pending_colors.pop_front();
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("status", want.status, out_status);
        case (want.status)
          cspar_pkg::ST_HEX: begin
            seen_hex++;
          end
          cspar_pkg::ST_NAME: begin
            seen_name++;
          end
          default: begin
            seen_none++;
          end
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [7:0] str [$];
    color_t     none_col;
    int         kind;
    int         pick;
    int         v;
    int         n;
    int         rand_chars;
    none_col     = '{8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE};
    rand_chars   = 0;
    errors       = 0;
    strings_sent = 0;
    chars_sent   = 0;
    seen_hex     = 0;
    seen_name    = 0;
    seen_none    = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_ch        = 8'h00;
    in_last_char = 1'b0;
    clear_scan();

    // Directed strings: hex extremes and mixed case, names in odd case,
    // short and long hex, bad digit, NUL bytes, bytes above 127, and a
    // string long enough to saturate the length count.
    add_row("#000000", 7, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_HEX);
    add_row("#FFFFFF", 7, 1, 8'hFF, 8'hFF, 8'hFF, cspar_pkg::ST_HEX);
    add_row("#aBc9D0", 7, 1, 8'hAB, 8'hC9, 8'hD0, cspar_pkg::ST_HEX);
    add_row("MaGeNtA", 7, 1, 8'hFF, 8'h00, 8'hFF, cspar_pkg::ST_NAME);
    add_row("black", 5, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NAME);
    add_row("WHITE", 5, 1, 8'hFF, 8'hFF, 8'hFF, cspar_pkg::ST_NAME);
    add_row("Orange", 6, 1, 8'hFF, 8'hA5, 8'h00, cspar_pkg::ST_NAME);
    add_row("#12345", 6, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("#1234567", 8, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("#12g456", 7, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("#", 1, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row({"re", 8'h00}, 3, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row(8'h00, 1, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row({"r", 8'hE5, "d"}, 3, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row(8'hFF, 1, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("redredredredredred", 18, 1, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("#abcdef", 7, 0, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("grey", 4, 0, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("GrAy", 4, 0, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("blue", 4, 0, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("purple", 6, 0, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("cyan", 4, 0, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("yellow", 6, 0, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("green", 5, 0, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("RED", 3, 0, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);
    add_row("gre", 3, 0, 8'h00, 8'h00, 8'h00, cspar_pkg::ST_NONE);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[r]) begin
      for (int i = 0; i < rows[r].len; i++) begin
        send_char(rows[r].text[8*(rows[r].len-1-i) +: 8], i == rows[r].len - 1,
                  rows[r].fixed, rows[r].want);
      end
    end

    // Random strings: mostly well-formed hex and names with random case,
    // some of them damaged, the rest plain byte noise.
    while (rand_chars < RAND_CHARS) begin
      str.delete();
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        str.push_back(HASH_BYTE);
        repeat (6) begin
          v = $urandom_range(0, 15);
          if (v < 10) str.push_back(8'("0" + v));
          else if ($urandom_range(0, 1)) str.push_back(8'("A" + v - 10));
          else str.push_back(8'("a" + v - 10));
        end
      end else if (kind < 70) begin
        pick = $urandom_range(0, 11);
        for (int i = 0; i < pal_name[pick].len(); i++) begin
          if ($urandom_range(0, 1)) str.push_back(8'(pal_name[pick][i] - 32));
          else str.push_back(8'(pal_name[pick][i]));
        end
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) str.push_back(8'("a" + $urandom_range(0, 25)));
          else str.push_back(8'($urandom_range(0, 255)));
        end
      end
      // Damage some well-formed strings: flip a byte, drop or add one.
      if (kind < 70) begin
        v = $urandom_range(0, 99);
        if (v < 12) begin
          str[$urandom_range(0, str.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (v < 18 && str.size() > 1) begin
          void'(str.pop_back());
        end else if (v < 24) begin
          str.push_back(8'("a" + $urandom_range(0, 25)));
        end
      end
      foreach (str[i]) begin
        send_char(str[i], i == str.size() - 1, 1'b0, none_col);
      end
      rand_chars += str.size();
    end
    in_valid <= 1'b0;

    // Drain: wait for every pending color, then let the pipeline settle.
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d strings in %0d character beats, random case and damage included.",
             strings_sent, chars_sent);
    $display("Checked %0d hex, %0d named and %0d unrecognized colors.",
             seen_hex, seen_name, seen_none);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
